[hw/rtl/icfm_pkg.sv]
// Shared widths, constants and control and status structs of the input capture frequency meter.
package icfm_pkg;

	localparam int unsigned CAP_W    = 16;
	localparam int unsigned PERIOD_W = 17;
	localparam int unsigned FREQ_W   = 31;
	localparam int unsigned CLK_W    = 32;
	localparam int unsigned DIVSR_W  = PERIOD_W + 1;
	localparam int unsigned STEP_W   = 5;

	localparam logic [CLK_W-1:0]  CLOCK_RESET = 32'd100000000;
	localparam logic [STEP_W-1:0] LAST_STEP   = 5'd31;

	typedef struct packed {
		logic start;
		logic take;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[hw/rtl/icfm_if.sv]
// Valid/ready channel interfaces for capture beats and result beats.
interface icfm_cap_if
	import icfm_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capture_value;

	modport source (output valid, output capture_value, input ready);
	modport sink (input valid, input capture_value, output ready);
endinterface

interface icfm_res_if
	import icfm_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [PERIOD_W-1:0] period_ticks;
	logic [FREQ_W-1:0]   frequency_hz;

	modport source (output valid, output period_ticks, output frequency_hz, input ready);
	modport sink (input valid, input period_ticks, input frequency_hz, output ready);
endinterface

[hw/rtl/input_capture_frequency_meter.sv]
// Top level of the input capture frequency meter: phase tracking, period and result register.
//
// Usage:
// - capture: valid/ready channel of 16-bit timer capture values, one beat per capture edge.
//   Beats pair up: the first of a pair is stored and yields nothing, the second yields
//   one result beat.
// - result: valid/ready channel carrying period_ticks (1..65536, equal captures count as
//   one full wrap) and frequency_hz = core_clock_hz / (2 * period_ticks), truncated.
// - cfg_wr_en/cfg_wr_data: write core_clock_hz (reset 100000000) while the block is idle.
// Timing: the first beat of a pair is only stored in first_capture_q. The second beat starts
// a bit-serial divider that retires one quotient bit per cycle over its 32-step loop; the
// quotient then moves into the result register, and no new capture is taken before that.
// capture.ready is low while the divider runs or holds a finished quotient.
// Stall: the result register holds its beat until taken; meanwhile the next pair can be
// accepted and divided, and the quotient then waits in the divider until the register frees.
// Reset: clears the phase, the stored capture, the result valid and the divider control, and
// loads core_clock_hz with its default.
module input_capture_frequency_meter
	import icfm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CLK_W-1:0]  cfg_wr_data,
	icfm_cap_if.sink          capture,
	icfm_res_if.source        result
);

	logic                second_phase_q;
	logic [CAP_W-1:0]    first_capture_q;
	logic [CLK_W-1:0]    core_clock_hz_q;
	logic [PERIOD_W-1:0] period_q;
	logic                out_valid_q;
	logic [PERIOD_W-1:0] out_period_q;
	logic [FREQ_W-1:0]   out_freq_q;

	logic                cap_beat;
	logic [CAP_W-1:0]    diff;
	logic [PERIOD_W-1:0] period;
	logic                push;
	div_ctrl_t           div_ctrl;
	div_stat_t           div_stat;
	logic [CLK_W-1:0]    quotient;

	// Accept captures only while the divider is neither running nor holding a quotient.
	assign capture.ready = ~(div_stat.busy | div_stat.done);
	assign cap_beat      = capture.valid & capture.ready;

	// Modulo-65536 distance; a zero difference means one full wrap.
	assign diff   = capture.capture_value - first_capture_q;
	assign period = {(diff == '0), diff};

	// Move the finished quotient once the result register is free or being drained.
	assign push = div_stat.done & (~out_valid_q | result.ready);

	assign div_ctrl.start = cap_beat & second_phase_q;
	assign div_ctrl.take  = push;

	icfm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (core_clock_hz_q),
		.divisor  ({period, 1'b0}),
		.stat     (div_stat),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_phase_q  <= 1'b0;
			first_capture_q <= '0;
			core_clock_hz_q <= CLOCK_RESET;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				core_clock_hz_q <= cfg_wr_data;
			end
			if (cap_beat) begin
				second_phase_q <= ~second_phase_q;
				if (!second_phase_q) begin
					first_capture_q <= capture.capture_value;
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the period beside the divider; load the result payload on push.
	always_ff @(posedge clk) begin
		if (div_ctrl.start) begin
			period_q <= period;
		end
		if (push) begin
			out_period_q <= period_q;
			out_freq_q   <= quotient[FREQ_W-1:0];
		end
	end

	assign result.valid        = out_valid_q;
	assign result.period_ticks = out_period_q;
	assign result.frequency_hz = out_freq_q;

`ifndef SYNTHESIS
	a_start_runs : assert property (@(posedge clk) disable iff (!arst_n)
		div_ctrl.start |=> div_stat.busy)
		else $error("divider did not start on second capture");

	a_busy_done_excl : assert property (@(posedge clk) disable iff (!arst_n)
		!(div_stat.busy && div_stat.done))
		else $error("divider busy and done together");

	a_result_period : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_period_q != '0))
		else $error("result with zero period");

	a_done_blocks_in : assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done && !push |=> div_stat.done && !capture.ready)
		else $error("pending quotient lost or capture accepted");
`endif

endmodule

[hw/rtl/icfm_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module icfm_div
	import icfm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  div_ctrl_t           ctrl,
	input  logic [CLK_W-1:0]    dividend,
	input  logic [DIVSR_W-1:0]  divisor,
	output div_stat_t           stat,
	output logic [CLK_W-1:0]    quotient
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIVSR_W-1:0] rem_q;
	logic [CLK_W-1:0]   quo_q;
	logic [DIVSR_W-1:0] divsr_q;

	logic [DIVSR_W:0] shifted;
	logic [DIVSR_W:0] trial;
	logic             fits;

	// Shift one dividend bit into the partial remainder and try a subtract.
	assign shifted = {rem_q, quo_q[CLK_W-1]};
	assign trial   = shifted - {1'b0, divsr_q};
	assign fits    = ~trial[DIVSR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (ctrl.start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (ctrl.take) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q   <= '0;
			quo_q   <= dividend;
			divsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DIVSR_W-1:0] : shifted[DIVSR_W-1:0];
			quo_q <= {quo_q[CLK_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

[tb/sv/input_capture_frequency_meter_tb.sv]
// Self-checking testbench for the input capture frequency meter.
module input_capture_frequency_meter_tb;
	import icfm_pkg::*;

	// Cycles to let pass after the last result before a clock write or the
	// final verdict. Allow more than the divider takes for the second beat of a pair.
	localparam int DIV_LATENCY = 40;
	// Cycles without any accepted beat before the run is declared hung.
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [PERIOD_W-1:0] period_ticks;
		logic [FREQ_W-1:0]   frequency_hz;
	} reading_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CLK_W-1:0] cfg_wr_data;

	icfm_cap_if cap_ch ();
	icfm_res_if res_ch ();

	input_capture_frequency_meter uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.capture     (cap_ch),
		.result      (res_ch)
	);

	// Captures waiting to be driven, and readings waiting to come out.
	logic [CAP_W-1:0] capture_backlog[$];
	reading_t         expected_readings[$];

	// Shadow of the block: clock register, open pair flag, stored capture.
	logic [CLK_W-1:0] clock_hz_shadow;
	bit               pair_open;
	logic [CAP_W-1:0] held_capture;

	bit allow_idle = 1'b1;
	int error_count = 0;
	int stall_cycles;
	int gap_left, src_quiet;
	int stall_left, sink_quiet;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Period is the modulo-65536 tick distance, where equal captures mean one
	// full wrap; frequency is the clock over twice the period, truncated.
	function automatic reading_t predict_reading(input logic [CAP_W-1:0] first_cap,
			input logic [CAP_W-1:0] second_cap, input logic [CLK_W-1:0] clock_hz);
		logic [CAP_W-1:0]    ticks_mod;
		logic [PERIOD_W-1:0] ticks;
		logic [63:0]         quotient;
		reading_t            r;
		ticks_mod = second_cap - first_cap;
		ticks = (ticks_mod == '0) ? {1'b1, {CAP_W{1'b0}}} : {1'b0, ticks_mod};
		quotient = 64'(clock_hz) / (64'(ticks) * 64'd2);
		r.period_ticks = ticks;
		r.frequency_hz = quotient[FREQ_W-1:0];
		return r;
	endfunction

	// Capture driver: hold each beat until taken, insert random gaps between beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_ch.valid <= 1'b0;
			cap_ch.capture_value <= '0;
			gap_left <= 0;
			src_quiet <= 0;
		end else begin
			// Alternate bursty stretches with quiet ones that never idle.
			src_quiet <= (src_quiet != 0) ? src_quiet - 1 :
				(($urandom_range(0, 63) == 0) ? int'($urandom_range(20, 60)) : 0);
			if (!cap_ch.valid || cap_ch.ready) begin
				if (gap_left != 0) begin
					cap_ch.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (capture_backlog.size() != 0) begin
					cap_ch.valid <= 1'b1;
					cap_ch.capture_value <= capture_backlog.pop_front();
					if (allow_idle && src_quiet == 0 && $urandom_range(0, 3) == 0)
						gap_left <= $urandom_range(1, 10);
				end else begin
					cap_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result sink: drop ready in bursts of random length.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left <= 0;
			sink_quiet <= 0;
		end else begin
			sink_quiet <= (sink_quiet != 0) ? sink_quiet - 1 :
				(($urandom_range(0, 63) == 0) ? int'($urandom_range(20, 60)) : 0);
			if (stall_left != 0) begin
				res_ch.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (allow_idle && sink_quiet == 0 && $urandom_range(0, 4) == 0) begin
				res_ch.ready <= 1'b0;
				stall_left <= $urandom_range(0, 9);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: check result beats, predict from capture beats, watch for a hang.
	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			pair_open = 1'b0;
			held_capture = '0;
			stall_cycles <= 0;
		end else begin
			// Check results first so a beat in the same cycle cannot mask an extra one.
			if (res_ch.valid && res_ch.ready) begin
				if (expected_readings.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: unexpected result period=%0d freq=%0d", $time,
							res_ch.period_ticks, res_ch.frequency_hz);
				end else begin
					want = expected_readings.pop_front();
					if (res_ch.period_ticks !== want.period_ticks ||
							res_ch.frequency_hz !== want.frequency_hz) begin
						error_count++;
						if (error_count <= 10)
							$display("%0t: mismatch period exp=%0d act=%0d freq exp=%0d act=%0d",
								$time, want.period_ticks, res_ch.period_ticks,
								want.frequency_hz, res_ch.frequency_hz);
					end
				end
			end
			// First beat of a pair is stored; the second yields one reading.
			if (cap_ch.valid && cap_ch.ready) begin
				if (!pair_open) begin
					held_capture = cap_ch.capture_value;
					pair_open = 1'b1;
				end else begin
					expected_readings.push_back(predict_reading(held_capture,
						cap_ch.capture_value, clock_hz_shadow));
					pair_open = 1'b0;
				end
			end
			if ((cap_ch.valid && cap_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic push_pair(input logic [CAP_W-1:0] first_cap, input logic [CAP_W-1:0] second_cap);
		capture_backlog.push_back(first_cap);
		capture_backlog.push_back(second_cap);
	endtask

	// Random pairs, biased toward equal captures, short periods and near-full wraps.
	task automatic queue_pairs(input int n_pairs);
		logic [CAP_W-1:0] first_cap;
		logic [CAP_W-1:0] second_cap;
		repeat (n_pairs) begin
			first_cap = CAP_W'($urandom_range(0, 65535));
			case ($urandom_range(0, 7))
				0: second_cap = first_cap;
				1: second_cap = first_cap + CAP_W'($urandom_range(1, 16));
				2: second_cap = first_cap - CAP_W'($urandom_range(1, 16));
				3: second_cap = first_cap + CAP_W'($urandom_range(1, 2000));
				default: second_cap = CAP_W'($urandom_range(0, 65535));
			endcase
			push_pair(first_cap, second_cap);
		end
	endtask

	// Wait until every capture is taken and every reading has come, then let
	// the divider drain before anything else touches the block.
	task automatic settle();
		while (capture_backlog.size() != 0 || cap_ch.valid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (DIV_LATENCY) @(posedge clk);
	endtask

	task automatic write_clock(input logic [CLK_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		clock_hz_shadow = value;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		cap_ch.valid = 1'b0;
		cap_ch.capture_value = '0;
		res_ch.ready = 1'b0;
		clock_hz_shadow = CLOCK_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed pairs at the reset clock: full wrap from equal captures,
		// wrap across zero, one-tick and near-full periods, alternating bits.
		push_pair(16'h0000, 16'h0000);
		push_pair(16'h0000, 16'hFFFF);
		push_pair(16'hFFFF, 16'h0000);
		push_pair(16'h0001, 16'h0000);
		push_pair(16'h1234, 16'h1235);
		push_pair(16'hFFFF, 16'hFFFF);
		push_pair(16'h8000, 16'h7FFF);
		push_pair(16'h5555, 16'hAAAA);
		push_pair(16'hAAAA, 16'h5555);
		push_pair(16'h0000, 16'h0001);
		settle();

		// Largest clock: one-tick period gives the largest frequency.
		write_clock(32'hFFFF_FFFF);
		push_pair(16'h0000, 16'h0001);
		push_pair(16'h7FFF, 16'h7FFF);
		queue_pairs(60);
		// Leave a pair open across the next clock write.
		capture_backlog.push_back(16'h00FF);
		settle();

		// Smallest nonzero clock: the quotient is always zero.
		write_clock(32'd1);
		capture_backlog.push_back(16'h0100);
		queue_pairs(40);
		settle();

		// Zero clock register is accepted and also yields zero.
		write_clock(32'd0);
		queue_pairs(20);
		settle();

		write_clock(CLOCK_RESET);
		queue_pairs(40);
		repeat (2) begin
			settle();
			write_clock(CLK_W'($urandom));
			queue_pairs(40);
		end
		settle();
		write_clock(CLK_W'($urandom_range(2, 200000)));
		queue_pairs(40);
		settle();

		// Final stretch runs both channels at full rate.
		allow_idle = 1'b0;
		write_clock(CLK_W'($urandom));
		queue_pairs(30);
		settle();

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
